@@ rtl/multi_timer_deadline_table_unit_macros.svh @@
// Assertion macros shared by the timer table modules.
`ifndef MULTI_TIMER_DEADLINE_TABLE_UNIT_MACROS_SVH
`define MULTI_TIMER_DEADLINE_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MTDT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtdt: assertion failed");
`define MTDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtdt: assertion failed");
`else
`define MTDT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MTDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/mtdt_pkg.sv @@
`timescale 1ns / 1ps
package mtdt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_SLOTS     = 16;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 4;
  localparam int PAY_W  = 8;
  localparam int DST_W  = 2;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int TAG_W  = PAY_W + DST_W;

  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_INIT    = 3'd2;
  localparam logic [OP_W-1:0] OP_SETTIME = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  localparam logic [STAT_W-1:0] ST_FREE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC = 2'd1;
  localparam logic [STAT_W-1:0] ST_RUN   = 2'd2;

  localparam logic [TIME_W-1:0] NO_DEADLINE = 32'hffff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [PAY_W-1:0]  payload;
    logic [DST_W-1:0]  destination;
    logic [TIME_W-1:0] delay;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_out;
    logic [PAY_W-1:0]  payload_out;
    logic [DST_W-1:0]  destination_out;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic alloc_grant;
    logic alloc_fail;
    logic ndl_clear;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic hit;
    logic stall;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/mtdt_if.sv @@
`timescale 1ns / 1ps
interface mtdt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mtdt_ctrl.sv @@
`timescale 1ns / 1ps
`include "multi_timer_deadline_table_unit_macros.svh"
module mtdt_ctrl import mtdt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int EFF = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS,
  localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [OP_W-1:0]  in_op,
  output logic             in_ready,
  input  stat_t            stat,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] addr
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_TCHK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(EFF - 1);

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  assign addr = idx;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    cmd.take   = in_ready && in_valid;
    case (state)
      S_IDLE: begin
        if (cmd.take) begin
          idx_next = '0;
          if (in_op == OP_ALLOC) begin
            state_next = S_ALLOC;
          end else if (in_op == OP_TICK) begin
            state_next = S_TCHK;
          end
        end
      end
      S_ALLOC: begin
        if (stat.slot_free) begin
          if (stat.out_free) begin
            cmd.alloc_grant = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (idx == LAST) begin
          if (stat.out_free) begin
            cmd.alloc_fail = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_TCHK: begin
        if (stat.hit) begin
          cmd.ndl_clear = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stat.stall) begin
          cmd.rd_en = 1'b1;
          if (idx == LAST) begin
            state_next = S_DRAIN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if (!stat.stall) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!stat.pend_valid || stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  `MTDT_ASSERT_NEXT(a_alloc_starts_scan, clk, rst, cmd.take && in_op == OP_ALLOC, state == S_ALLOC)
  `MTDT_ASSERT_NEXT(a_scan_holds_on_stall, clk, rst, state == S_SCAN && stat.stall, $stable(idx))
  `MTDT_ASSERT_IMPL(a_no_take_when_busy, clk, rst, state != S_IDLE, !cmd.take)

endmodule

@@ rtl/mtdt_dp.sv @@
`timescale 1ns / 1ps
`include "multi_timer_deadline_table_unit_macros.svh"
module mtdt_dp import mtdt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int EFF = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS,
  localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  in_word_t         in_word,
  input  cmd_t             cmd,
  input  logic [IDX_W-1:0] addr,
  output stat_t            stat,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             out_ready
);

  logic [TIME_W-1:0] tick_count;
  logic [TIME_W-1:0] next_deadline;
  logic [STAT_W-1:0] slot_status [EFF];
  logic [TIME_W-1:0] dl_mem [EFF];
  logic [TAG_W-1:0]  tag_mem [EFF];

  logic              s2_valid;
  logic [IDX_W-1:0]  s2_idx;
  logic [TIME_W-1:0] s2_dl;
  logic [TAG_W-1:0]  s2_tag;

  logic              pend_valid;
  logic [IDX_W-1:0]  pend_idx;
  logic [TAG_W-1:0]  pend_tag;

  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [TIME_W-1:0] set_dl;
  logic              s2_run;
  logic              expire;
  logic              upd;
  logic              stall;
  logic              out_free;
  logic              push_pend;
  logic              flush_push;
  logic              push;
  out_word_t         push_word;

  assign slot_ok  = {1'b0, in_word.slot} < (SLOT_W + 1)'(EFF);
  assign slot_idx = in_word.slot[IDX_W-1:0];
  assign set_dl   = in_word.delay + tick_count;

  assign out_free   = !out_valid || out_ready;
  assign s2_run     = (slot_status[s2_idx] == ST_RUN);
  assign expire     = s2_valid && s2_run && (s2_dl <= tick_count);
  assign upd        = s2_valid && s2_run && !expire && (next_deadline > s2_dl);
  assign stall      = expire && pend_valid && !out_free;
  assign push_pend  = expire && pend_valid && !stall;
  assign flush_push = cmd.flush && pend_valid && out_free;
  assign push       = cmd.alloc_grant || cmd.alloc_fail || push_pend || flush_push;

  assign stat.slot_free  = (slot_status[addr] == ST_FREE);
  assign stat.hit        = (next_deadline <= tick_count);
  assign stat.stall      = stall;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

  always_comb begin
    push_word = '0;
    if (cmd.alloc_grant) begin
      push_word.kind     = KIND_GRANT;
      push_word.slot_out = SLOT_W'(addr);
      push_word.last     = 1'b1;
    end else if (cmd.alloc_fail) begin
      push_word.kind = KIND_FAIL;
      push_word.last = 1'b1;
    end else begin
      push_word.kind            = KIND_EXPIRED;
      push_word.slot_out        = SLOT_W'(pend_idx);
      push_word.payload_out     = pend_tag[TAG_W-1:DST_W];
      push_word.destination_out = pend_tag[DST_W-1:0];
      push_word.last            = flush_push;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      next_deadline <= NO_DEADLINE;
      for (int i = 0; i < EFF; i++) begin
        slot_status[i] <= ST_FREE;
      end
    end else begin
      if (cmd.take) begin
        case (in_word.op)
          OP_FREE: begin
            if (slot_ok) begin
              slot_status[slot_idx] <= ST_FREE;
            end
          end
          OP_SETTIME: begin
            if (slot_ok) begin
              slot_status[slot_idx] <= ST_RUN;
              if (next_deadline > set_dl) begin
                next_deadline <= set_dl;
              end
            end
          end
          OP_TICK: begin
            tick_count <= tick_count + 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.alloc_grant) begin
        slot_status[addr] <= ST_ALLOC;
      end
      if (cmd.ndl_clear) begin
        next_deadline <= NO_DEADLINE;
      end
      if (expire && !stall) begin
        slot_status[s2_idx] <= ST_ALLOC;
      end else if (upd) begin
        next_deadline <= s2_dl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && slot_ok && in_word.op == OP_SETTIME) begin
      dl_mem[slot_idx] <= set_dl;
    end
    if (cmd.take && slot_ok && in_word.op == OP_INIT) begin
      tag_mem[slot_idx] <= {in_word.payload, in_word.destination};
    end
    if (cmd.rd_en) begin
      s2_dl  <= dl_mem[addr];
      s2_tag <= tag_mem[addr];
      s2_idx <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (cmd.rd_en) begin
      s2_valid <= 1'b1;
    end else if (!stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (expire && !stall) begin
      pend_valid <= 1'b1;
    end else if (flush_push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (expire && !stall) begin
      pend_idx <= s2_idx;
      pend_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_word <= push_word;
    end
  end

  `MTDT_ASSERT_IMPL(a_grant_hits_free_slot, clk, rst, cmd.alloc_grant, slot_status[addr] == ST_FREE)
  `MTDT_ASSERT_IMPL(a_push_has_room, clk, rst, push, out_free)
  `MTDT_ASSERT_NEXT(a_expired_leaves_run, clk, rst, expire && !stall, slot_status[$past(s2_idx)] == ST_ALLOC)

endmodule

@@ rtl/multi_timer_deadline_table_unit.sv @@
`timescale 1ns / 1ps
// Free, init and settime complete at acceptance; the next word is accepted the cycle after.
// Alloc scans one slot per cycle and loads its word into the output register once the output is free.
// Tick checks the next deadline against the new count; if it is reached, an expiry scan follows,
// which reads the deadline memory one slot per cycle; a stalled output stretches both scans.
// Reset clears the count, the next deadline and all slot states; slot data is undefined until set.
module multi_timer_deadline_table_unit import mtdt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int EFF = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS,
  localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1
) (
  input logic clk,
  input logic rst,
  mtdt_if.sink   in_ch,
  mtdt_if.source out_ch
);

  in_word_t         in_word;
  out_word_t        out_word;
  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] addr;
  logic             in_ready;
  logic             out_valid;

  assign in_word      = in_ch.data;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  mtdt_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_word.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .addr     (addr)
  );

  mtdt_dp #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_ready (out_ch.ready)
  );

endmodule

@@ tb/multi_timer_deadline_table_unit_test.sv @@
`timescale 1ns / 1ps
module multi_timer_deadline_table_unit_test import mtdt_pkg::*;;

  localparam int SLOTS        = NUM_SLOTS_DEF;
  localparam int EFF_SLOTS    = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_WORDS = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int TIMEOUT_NS   = 400_000;

  logic clk = 1'b0;
  logic rst;

  mtdt_if #(.T(in_word_t))  in_ch ();
  mtdt_if #(.T(out_word_t)) out_ch ();

  multi_timer_deadline_table_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  logic [TIME_W-1:0] now_ticks;
  logic [TIME_W-1:0] earliest_due;
  logic [STAT_W-1:0] slot_state [MAX_SLOTS];
  logic [TIME_W-1:0] slot_due [MAX_SLOTS];
  logic [PAY_W-1:0]  slot_pay [MAX_SLOTS];
  logic [DST_W-1:0]  slot_dst [MAX_SLOTS];
  bit                slot_tagged [MAX_SLOTS];

  out_word_t pending_events [$];
  out_word_t want_word;
  int        mismatch_count = 0;
  int        words_sent = 0;
  int        burst_left = 0;
  bit        hold_req = 1'b0;

  task automatic clear_timer_model();
    now_ticks = '0;
    earliest_due = NO_DEADLINE;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_state[i] = ST_FREE;
      slot_due[i] = '0;
      slot_pay[i] = '0;
      slot_dst[i] = '0;
      slot_tagged[i] = 1'b0;
    end
  endtask

  task automatic advance_timers(input in_word_t w);
    out_word_t         r;
    logic [TIME_W-1:0] due;
    int                last_hit;
    bit                granted;
    bit                in_range;
    in_range = (int'(w.slot) < EFF_SLOTS);
    r = '0;
    case (w.op)
      OP_ALLOC: begin
        granted = 1'b0;
        for (int i = 0; i < EFF_SLOTS; i++) begin
          if (!granted && slot_state[i] == ST_FREE) begin
            granted = 1'b1;
            slot_state[i] = ST_ALLOC;
            r.kind = KIND_GRANT;
            r.slot_out = i[SLOT_W-1:0];
          end
        end
        if (!granted) begin
          r.kind = KIND_FAIL;
        end
        r.last = 1'b1;
        pending_events.push_back(r);
      end
      OP_FREE: begin
        if (in_range) begin
          slot_state[w.slot] = ST_FREE;
        end
      end
      OP_INIT: begin
        if (in_range) begin
          slot_pay[w.slot] = w.payload;
          slot_dst[w.slot] = w.destination;
          slot_tagged[w.slot] = 1'b1;
        end
      end
      OP_SETTIME: begin
        if (in_range) begin
          due = w.delay + now_ticks;
          slot_due[w.slot] = due;
          slot_state[w.slot] = ST_RUN;
          if (earliest_due > due) begin
            earliest_due = due;
          end
        end
      end
      OP_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (earliest_due <= now_ticks) begin
          earliest_due = NO_DEADLINE;
          last_hit = -1;
          for (int i = 0; i < EFF_SLOTS; i++) begin
            if (slot_state[i] == ST_RUN && slot_due[i] <= now_ticks) begin
              last_hit = i;
            end
          end
          for (int i = 0; i < EFF_SLOTS; i++) begin
            if (slot_state[i] == ST_RUN) begin
              if (slot_due[i] <= now_ticks) begin
                slot_state[i] = ST_ALLOC;
                r.kind = KIND_EXPIRED;
                r.slot_out = i[SLOT_W-1:0];
                r.payload_out = slot_pay[i];
                r.destination_out = slot_dst[i];
                r.last = (i == last_hit);
                pending_events.push_back(r);
              end else if (earliest_due > slot_due[i]) begin
                earliest_due = slot_due[i];
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_word_t make_word(input logic [OP_W-1:0] op, input int s);
    in_word_t w;
    w.op = op;
    w.slot = s[SLOT_W-1:0];
    w.payload = PAY_W'($urandom);
    w.destination = DST_W'($urandom);
    w.delay = $urandom;
    return w;
  endfunction

  function automatic logic [TIME_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return TIME_W'($urandom_range(0, 8));
    end else if (r < 75) begin
      return TIME_W'($urandom_range(9, 60));
    end else if (r < 90) begin
      return $urandom;
    end
    return NO_DEADLINE - TIME_W'($urandom_range(0, 6));
  endfunction

  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_timers(w);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int s);
    send_word(make_word(op, s));
  endtask

  task automatic arm_timer(input int s, input logic [TIME_W-1:0] dly);
    in_word_t w;
    if (!slot_tagged[s]) begin
      send_op(OP_INIT, s);
    end
    w = make_word(OP_SETTIME, s);
    w.delay = dly;
    send_word(w);
  endtask

  task automatic wait_for_all_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic test_alloc_exhaust();
    for (int i = 0; i <= EFF_SLOTS; i++) begin
      send_op(OP_ALLOC, i);
    end
    send_op(OP_FREE, EFF_SLOTS - 1);
    send_op(OP_ALLOC, 0);
  endtask

  task automatic test_expiry_extremes();
    in_word_t w;
    w = make_word(OP_INIT, 0);
    w.payload = '1;
    w.destination = '1;
    send_word(w);
    w = make_word(OP_INIT, EFF_SLOTS - 1);
    w.payload = '0;
    w.destination = '0;
    send_word(w);
    arm_timer(0, '0);
    arm_timer(EFF_SLOTS - 1, '0);
    send_op(OP_TICK, 0);
    arm_timer(0, NO_DEADLINE);
    send_op(OP_TICK, EFF_SLOTS - 1);
  endtask

  task automatic test_free_running_slot();
    arm_timer(EFF_SLOTS - 1, TIME_W'(1));
    send_op(OP_FREE, EFF_SLOTS - 1);
    send_op(OP_TICK, 0);
  endtask

  task automatic test_unknown_ops();
    for (int k = 1; k <= 3; k++) begin
      send_op(OP_TICK + OP_W'(k), $urandom_range(0, EFF_SLOTS - 1));
    end
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    for (int i = 0; i < EFF_SLOTS; i++) begin
      arm_timer(i, TIME_W'($urandom_range(0, 2)));
    end
    repeat (3) send_op(OP_TICK, 0);
    repeat (3) send_op(OP_ALLOC, 0);
    send_op(OP_FREE, $urandom_range(0, EFF_SLOTS - 1));
    send_op(OP_ALLOC, 0);
  endtask

  task automatic test_random_traffic();
    int  start;
    int  r;
    int  s;
    bit  paused;
    start = words_sent;
    paused = 1'b0;
    while (words_sent < start + RANDOM_WORDS) begin
      if (!paused && words_sent >= start + RANDOM_WORDS / 2) begin
        wait_for_all_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 20) begin
        s = -1;
        for (int i = EFF_SLOTS - 1; i >= 0; i--) begin
          if (slot_state[i] == ST_FREE) s = i;
        end
        send_op(OP_ALLOC, 0);
        if (s >= 0) begin
          send_op(OP_INIT, s);
          arm_timer(s, pick_delay());
        end
      end else if (r < 30) begin
        send_op(OP_FREE, $urandom_range(0, EFF_SLOTS - 1));
      end else if (r < 38) begin
        send_op(OP_INIT, $urandom_range(0, EFF_SLOTS - 1));
      end else if (r < 55) begin
        arm_timer($urandom_range(0, EFF_SLOTS - 1), pick_delay());
      end else if (r < 97) begin
        send_op(OP_TICK, $urandom_range(0, EFF_SLOTS - 1));
      end else begin
        send_op(OP_TICK + OP_W'($urandom_range(1, 3)), $urandom_range(0, EFF_SLOTS - 1));
      end
    end
  endtask

  initial begin
    int recv_mode;
    int recv_phase;
    int hold_left;
    recv_mode = 0;
    recv_phase = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      recv_phase++;
      if (recv_phase % 50 == 0) begin
        recv_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (recv_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= recv_phase[0];
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected word: kind=%0d slot=%0d payload=%0h dest=%0d last=%0d",
                   out_ch.data.kind, out_ch.data.slot_out, out_ch.data.payload_out,
                   out_ch.data.destination_out, out_ch.data.last);
        end
      end else begin
        want_word = pending_events.pop_front();
        if (out_ch.data.kind !== want_word.kind ||
            out_ch.data.slot_out !== want_word.slot_out ||
            out_ch.data.payload_out !== want_word.payload_out ||
            out_ch.data.destination_out !== want_word.destination_out ||
            out_ch.data.last !== want_word.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("word differs: expected kind=%0d slot=%0d payload=%0h dest=%0d last=%0d",
                     want_word.kind, want_word.slot_out, want_word.payload_out,
                     want_word.destination_out, want_word.last);
            $display("              actual   kind=%0d slot=%0d payload=%0h dest=%0d last=%0d",
                     out_ch.data.kind, out_ch.data.slot_out, out_ch.data.payload_out,
                     out_ch.data.destination_out, out_ch.data.last);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("multi_timer_deadline_table_unit: mismatch");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    clear_timer_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alloc_exhaust();
    test_expiry_extremes();
    test_free_running_slot();
    test_unknown_ops();
    test_output_hold();
    test_random_traffic();
    wait_for_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("multi_timer_deadline_table_unit: match");
    end else begin
      $display("multi_timer_deadline_table_unit: mismatch");
    end
    $finish;
  end

endmodule
